// ----- rtl/generational_handle_allocator_defines.svh -----
// Assertion macros shared by the handle allocator RTL.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define GHA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define GHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- rtl/gha_pkg.sv -----
// Types and constants of the generational handle allocator.
`default_nettype none

package gha_pkg;

   localparam int MAX_SLOTS = 1024;
   localparam int IDX_W     = 10;
   localparam int GEN_W     = 16;
   localparam int CNT_W     = 11;

   typedef logic [2:0] opcode_type;

   localparam opcode_type OP_CREATE  = 3'd0;
   localparam opcode_type OP_DESTROY = 3'd1;
   localparam opcode_type OP_QUERY   = 3'd2;
   localparam opcode_type OP_SET_EN  = 3'd3;
   localparam opcode_type OP_CLEAR   = 3'd4;

   // request item
   typedef struct packed {
      opcode_type         opcode;
      logic [IDX_W-1:0]   handle_index;
      logic [GEN_W-1:0]   handle_generation;
      logic               enable_value;
   } gha_req_type;

   // result item
   typedef struct packed {
      logic [IDX_W-1:0]   out_index;
      logic [GEN_W-1:0]   out_generation;
      logic               created_ok;
      logic               handle_ok;
      logic               handle_enabled;
      logic [CNT_W-1:0]   living_count;
   } gha_rsp_type;

   // one slot table entry
   typedef struct packed {
      logic [GEN_W-1:0]   generation;
      logic               enabled;
      logic               destroyed;
   } slot_type;

   // free stack entry: slot index and the generation it will come back with
   typedef struct packed {
      logic [IDX_W-1:0]   index;
      logic [GEN_W-1:0]   generation;
   } stack_type;

endpackage

`default_nettype wire

// ----- rtl/generational_handle_allocator.sv -----
// Generational handle allocator: slot table, free stack and counters.
//
// Request channel (req_*): one operation per item - create, destroy, query,
// set enable mark or clear all. Result channel (rsp_*): exactly one result
// item per request item, in order. Both sides use valid/stall.
// An accepted item's result is registered as it leaves the execute stage.
// One item per cycle is sustained unless rsp_stall holds: the slot table
// and free stack RAMs are read when the item is accepted, and the
// read-modify-write plus stack push or pop finish as it leaves the stage;
// bypass registers cover a same-cycle write to the address just read.
// The result register parts the two sides: a new request is taken while a
// result waits. When rsp_stall holds, the item in the execute stage waits
// and req_stall rises once both execute stage and result register are full.
// Reset empties the pipeline, sets living count and free stack to zero and
// the used-slot mark to one (slot zero reserved). The RAM contents need no
// clearing pass: every entry is written before its contents are used.
`default_nettype none

`include "generational_handle_allocator_defines.svh"

module generational_handle_allocator
   import gha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire gha_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output gha_rsp_type      rsp_payload
);

   localparam int SLOT_W  = $bits(slot_type);
   localparam int STACK_W = $bits(stack_type);

   // execute stage
   logic         s1_valid_ff, s1_valid_in;
   gha_req_type  s1_req_ff;
   logic         fwd_slot_valid_ff, fwd_slot_valid_in;
   slot_type     fwd_slot_ff, fwd_slot_in;
   logic         fwd_stack_valid_ff, fwd_stack_valid_in;
   stack_type    fwd_stack_ff, fwd_stack_in;

   // architectural counters
   logic [CNT_W-1:0] free_top_ff, free_top_in;
   logic [CNT_W-1:0] slots_used_ff, slots_used_in;
   logic [CNT_W-1:0] living_ff, living_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   gha_rsp_type  rsp_ff, rsp_in;

   logic         req_accept;
   logic         s1_commit;

   // RAM ports
   logic [SLOT_W-1:0]  slot_q;
   logic [STACK_W-1:0] stack_q;
   logic               slot_we;
   logic [IDX_W-1:0]   slot_wa;
   slot_type           slot_wd;
   logic               stack_we;
   stack_type          stack_wd;
   logic [IDX_W-1:0]   stack_ra;

   slot_type           slot_cur;
   stack_type          stack_cur;
   logic               valid_hdl;
   logic [GEN_W-1:0]   gen_inc;

   // handshake
   assign s1_commit  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_commit;
   assign req_accept = req_valid && !req_stall;

   // bypass a write made in the same cycle the RAM was read
   assign slot_cur  = fwd_slot_valid_ff  ? fwd_slot_ff  : slot_type'(slot_q);
   assign stack_cur = fwd_stack_valid_ff ? fwd_stack_ff : stack_type'(stack_q);

   // handle check against the state left by the previous item
   assign valid_hdl = (s1_req_ff.handle_index != '0) &&
                      ({1'b0, s1_req_ff.handle_index} < slots_used_ff) &&
                      (slot_cur.generation == s1_req_ff.handle_generation) &&
                      !slot_cur.destroyed;

   // next generation, skipping zero
   always_comb begin
      gen_inc = slot_cur.generation + GEN_W'(1);
      if (gen_inc == '0) begin
         gen_inc = GEN_W'(1);
      end
   end

   // execute: one operation against slot table, stack and counters
   always_comb begin
      slot_we       = 1'b0;
      slot_wa       = s1_req_ff.handle_index;
      slot_wd       = slot_cur;
      stack_we      = 1'b0;
      stack_wd.index      = s1_req_ff.handle_index;
      stack_wd.generation = gen_inc;
      free_top_in   = free_top_ff;
      slots_used_in = slots_used_ff;
      living_in     = living_ff;
      rsp_in        = '0;

      case (s1_req_ff.opcode)
         OP_CREATE: begin
            if (free_top_ff != '0) begin
               free_top_in = free_top_ff - CNT_W'(1);
               slot_we     = 1'b1;
               slot_wa     = stack_cur.index;
               slot_wd     = '{generation: stack_cur.generation, enabled: 1'b1,
                               destroyed: 1'b0};
               rsp_in.out_index      = stack_cur.index;
               rsp_in.out_generation = stack_cur.generation;
               rsp_in.created_ok     = 1'b1;
            end else if (slots_used_ff < CNT_W'(MAX_SLOTS)) begin
               slots_used_in = slots_used_ff + CNT_W'(1);
               slot_we       = 1'b1;
               slot_wa       = slots_used_ff[IDX_W-1:0];
               slot_wd       = '{generation: GEN_W'(1), enabled: 1'b1, destroyed: 1'b0};
               rsp_in.out_index      = slots_used_ff[IDX_W-1:0];
               rsp_in.out_generation = GEN_W'(1);
               rsp_in.created_ok     = 1'b1;
            end
            if (rsp_in.created_ok && (living_ff != '1)) begin
               living_in = living_ff + CNT_W'(1);
            end
         end
         OP_DESTROY: begin
            rsp_in.handle_ok      = valid_hdl;
            rsp_in.handle_enabled = valid_hdl && slot_cur.enabled;
            if (valid_hdl) begin
               slot_we = 1'b1;
               slot_wd = '{generation: gen_inc, enabled: slot_cur.enabled,
                           destroyed: 1'b1};
               if (free_top_ff < CNT_W'(MAX_SLOTS)) begin
                  stack_we    = 1'b1;
                  free_top_in = free_top_ff + CNT_W'(1);
               end
               if (living_ff != '0) begin
                  living_in = living_ff - CNT_W'(1);
               end
            end
         end
         OP_QUERY: begin
            rsp_in.handle_ok      = valid_hdl;
            rsp_in.handle_enabled = valid_hdl && slot_cur.enabled;
         end
         OP_SET_EN: begin
            rsp_in.handle_ok      = valid_hdl;
            rsp_in.handle_enabled = valid_hdl && slot_cur.enabled;
            if (valid_hdl) begin
               slot_we = 1'b1;
               slot_wd = '{generation: slot_cur.generation,
                           enabled: s1_req_ff.enable_value,
                           destroyed: slot_cur.destroyed};
            end
         end
         OP_CLEAR: begin
            free_top_in   = '0;
            slots_used_in = CNT_W'(1);
            living_in     = '0;
         end
         default: begin
         end
      endcase

      rsp_in.living_count = living_in;

      // nothing changes unless the item leaves the stage
      if (!s1_commit) begin
         slot_we       = 1'b0;
         stack_we      = 1'b0;
         free_top_in   = free_top_ff;
         slots_used_in = slots_used_ff;
         living_in     = living_ff;
      end
   end

   // stack read address for the incoming item: top after this item
   assign stack_ra = free_top_in[IDX_W-1:0] - IDX_W'(1);

   // bypass capture and stage control
   always_comb begin
      s1_valid_in        = s1_valid_ff;
      fwd_slot_valid_in  = fwd_slot_valid_ff;
      fwd_slot_in        = fwd_slot_ff;
      fwd_stack_valid_in = fwd_stack_valid_ff;
      fwd_stack_in       = fwd_stack_ff;
      if (req_accept) begin
         s1_valid_in        = 1'b1;
         fwd_slot_valid_in  = slot_we && (slot_wa == req_payload.handle_index);
         fwd_slot_in        = slot_wd;
         fwd_stack_valid_in = stack_we;
         fwd_stack_in       = stack_wd;
      end else if (s1_commit) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         free_top_ff   <= '0;
         slots_used_ff <= CNT_W'(1);
         living_ff     <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_top_ff   <= free_top_in;
         slots_used_ff <= slots_used_in;
         living_ff     <= living_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_payload;
      end
      fwd_slot_valid_ff  <= fwd_slot_valid_in;
      fwd_slot_ff        <= fwd_slot_in;
      fwd_stack_valid_ff <= fwd_stack_valid_in;
      fwd_stack_ff       <= fwd_stack_in;
      if (s1_commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // slot table
   gha_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_en   (req_accept),
      .rd_addr (req_payload.handle_index),
      .rd_data (slot_q)
   );

   // free stack
   gha_ram #(
      .WIDTH (STACK_W),
      .DEPTH (MAX_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (free_top_ff[IDX_W-1:0]),
      .wr_data (stack_wd),
      .rd_en   (req_accept),
      .rd_addr (stack_ra),
      .rd_data (stack_q)
   );

   // every used slot is either living or on the free stack
   `GHA_ASSERT_IMP(a_count_balance, 1'b1, (living_ff + free_top_ff) == (slots_used_ff - CNT_W'(1)))
   // a created handle is never the null handle
   `GHA_ASSERT_IMP(a_create_nonnull, rsp_valid_ff && rsp_ff.created_ok, (rsp_ff.out_index != '0) && (rsp_ff.out_generation != '0))
   // an item taken in goes into the execute stage
   `GHA_ASSERT_NEXT(a_stage_fill, req_accept, s1_valid_ff)

endmodule

`default_nettype wire

// ----- rtl/gha_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for the generational handle allocator: random and directed traffic, in-order checking.
`timescale 1ns / 1ps

module tb_top
   import gha_pkg::*;
;

   // opcodes the block treats as no operation
   localparam opcode_type OP_SPARE5 = 3'd5;
   localparam opcode_type OP_SPARE6 = 3'd6;
   localparam opcode_type OP_SPARE7 = 3'd7;

   localparam int LIVING_MAX    = 2047;
   localparam int QUEUE_WINDOW  = 4;
   localparam int POOL_CAP      = 256;
   localparam int STALE_CAP     = 32;
   localparam int HOLD_CYCLES   = 60;
   localparam int STALL_LIMIT   = 3000;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [GEN_W-1:0] generation;
   } handle_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   gha_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   gha_rsp_type rsp_payload;

   generational_handle_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predicted allocator state
   bit [GEN_W-1:0] tbl_generation [MAX_SLOTS];
   bit             tbl_enabled    [MAX_SLOTS];
   bit             tbl_destroyed  [MAX_SLOTS];
   bit [IDX_W-1:0] free_slots     [MAX_SLOTS];
   int             free_depth  = 0;
   int             used_slots  = 1;
   int             living_total = 0;

   // handles handed out, for aiming later operations
   handle_type handle_pool [$];
   handle_type stale_handles [$];

   gha_req_type pending_reqs [$];
   gha_rsp_type expected_rsp_q [$];

   int  items_queued   = 0;
   int  items_accepted = 0;
   int  results_seen   = 0;
   int  mismatch_count = 0;
   int  creates_ok     = 0;
   int  creates_failed = 0;
   int  idle_cycles    = 0;
   int  send_idle_pct  = 0;
   int  stall_pct      = 0;
   int  hold_left      = 0;
   bit  hold_request   = 1'b0;
   bit  req_taken      = 1'b0;

   // expected result of one operation; advances the predicted state
   function automatic gha_rsp_type predict_handle_op(input gha_req_type item);
      gha_rsp_type    outcome;
      logic           known;
      bit [IDX_W-1:0] slot;
      bit [GEN_W-1:0] next_gen;
      bit             got;
      handle_type     h;
      int             idx;
      outcome = '0;
      got     = 1'b0;
      slot    = '0;
      idx     = int'(item.handle_index);
      known   = (idx != 0) && (idx < used_slots)
                && (tbl_generation[idx] == item.handle_generation) && !tbl_destroyed[idx];
      if (item.opcode == OP_DESTROY || item.opcode == OP_QUERY || item.opcode == OP_SET_EN) begin
         outcome.handle_ok      = known;
         outcome.handle_enabled = known && tbl_enabled[idx];
      end
      case (item.opcode)
         OP_CREATE: begin
            // most recently freed slot first, else a never-used one
            if (free_depth > 0) begin
               free_depth--;
               slot = free_slots[free_depth];
               got  = 1'b1;
            end else if (used_slots < MAX_SLOTS) begin
               slot = IDX_W'(used_slots);
               used_slots++;
               tbl_generation[slot] = GEN_W'(1);
               got = 1'b1;
            end
            if (got) begin
               tbl_enabled[slot]      = 1'b1;
               tbl_destroyed[slot]    = 1'b0;
               outcome.out_index      = slot;
               outcome.out_generation = tbl_generation[slot];
               outcome.created_ok     = 1'b1;
               if (living_total < LIVING_MAX) living_total++;
               h.index      = slot;
               h.generation = tbl_generation[slot];
               handle_pool = {handle_pool, h};
               if (handle_pool.size() > POOL_CAP) void'(handle_pool.pop_front());
               creates_ok++;
            end else begin
               creates_failed++;
            end
         end
         OP_DESTROY: begin
            if (known) begin
               // generation skips zero on wrap
               next_gen = tbl_generation[idx] + 1'b1;
               if (next_gen == 0) next_gen = GEN_W'(1);
               tbl_generation[idx] = next_gen;
               tbl_destroyed[idx]  = 1'b1;
               if (free_depth < MAX_SLOTS) begin
                  free_slots[free_depth] = IDX_W'(idx);
                  free_depth++;
               end
               if (living_total > 0) living_total--;
            end
         end
         OP_SET_EN: begin
            if (known) tbl_enabled[idx] = item.enable_value;
         end
         OP_CLEAR: begin
            used_slots   = 1;
            free_depth   = 0;
            living_total = 0;
            handle_pool.delete();
         end
         default: ;
      endcase
      outcome.living_count = CNT_W'(living_total);
      return outcome;
   endfunction

   function automatic gha_req_type make_req(input opcode_type op, input int unsigned idx,
                                            input int unsigned gen, input bit en);
      gha_req_type item;
      item.opcode            = op;
      item.handle_index      = idx[IDX_W-1:0];
      item.handle_generation = gen[GEN_W-1:0];
      item.enable_value      = en;
      return item;
   endfunction

   // a live or stale handle when one is known, else random bits
   function automatic handle_type pick_handle(input bit stale);
      handle_type h;
      h.index      = IDX_W'($urandom_range(0, MAX_SLOTS - 1));
      h.generation = GEN_W'($urandom_range(0, 65535));
      if (!stale && handle_pool.size() > 0)
         h = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
      else if (stale && stale_handles.size() > 0)
         h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
      return h;
   endfunction

   // destroy aimed at a live handle, which then goes to the stale list
   function automatic gha_req_type retire_item();
      handle_type h;
      int         k;
      h = pick_handle(1'b0);
      if (handle_pool.size() > 0) begin
         k = int'($urandom_range(0, handle_pool.size() - 1));
         h = handle_pool[k];
         handle_pool.delete(k);
         stale_handles = {stale_handles, h};
         if (stale_handles.size() > STALE_CAP) void'(stale_handles.pop_front());
      end
      return make_req(OP_DESTROY, 32'(h.index), 32'(h.generation), 1'($urandom_range(0, 1)));
   endfunction

   function automatic gha_req_type make_random_item();
      gha_req_type item;
      handle_type  h;
      int unsigned roll;
      int unsigned aim;
      roll = $urandom_range(0, 99);
      aim  = $urandom_range(0, 9);
      h    = pick_handle(aim >= 6);
      item = make_req(OP_CREATE, $urandom_range(0, MAX_SLOTS - 1),
                      $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      if (roll < 30) begin
         item.opcode = OP_CREATE;
      end else if (roll < 50) begin
         item = retire_item();
      end else if (roll < 68) begin
         item.opcode = OP_QUERY;
         if (aim < 9) {item.handle_index, item.handle_generation} = h;
      end else if (roll < 84) begin
         item.opcode = OP_SET_EN;
         if (aim < 9) {item.handle_index, item.handle_generation} = h;
      end else if (roll < 86) begin
         item.opcode = OP_CLEAR;
      end else if (roll < 92) begin
         item.opcode = opcode_type'($urandom_range(OP_SPARE5, OP_SPARE7));
      end else begin
         item.opcode = opcode_type'($urandom_range(OP_CREATE, OP_SPARE7));
      end
      return item;
   endfunction

   task automatic send_item(input gha_req_type item);
      while (pending_reqs.size() >= QUEUE_WINDOW) @(posedge clock);
      pending_reqs = {pending_reqs, item};
      items_queued++;
   endtask

   task automatic drain();
      while (items_accepted != items_queued || expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int count, input int idle_pct, input int stall_mix);
      send_idle_pct = idle_pct;
      stall_pct     = stall_mix;
      repeat (count) send_item(make_random_item());
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // request driver: holds an item until taken, idles at random
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall: random, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // monitor: predict on accepted requests, compare accepted results, watchdog
   always @(posedge clock) begin
      gha_rsp_type want;
      if (reset) begin
         req_taken   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            expected_rsp_q = {expected_rsp_q, predict_handle_op(req_payload)};
            items_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: result with nothing expected: %p", $time, rsp_payload);
               mismatch_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("out_index", 32'(want.out_index), 32'(rsp_payload.out_index));
               check_field("out_generation", 32'(want.out_generation),
                           32'(rsp_payload.out_generation));
               check_field("created_ok", 32'(want.created_ok), 32'(rsp_payload.created_ok));
               check_field("handle_ok", 32'(want.handle_ok), 32'(rsp_payload.handle_ok));
               check_field("handle_enabled", 32'(want.handle_enabled),
                           32'(rsp_payload.handle_enabled));
               check_field("living_count", 32'(want.living_count),
                           32'(rsp_payload.living_count));
            end
         end
         if (req_taken || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: fresh table hands out slot 1 then slot 2, both generation 1
      send_item(make_req(OP_QUERY, 0, 0, 1'b0));
      send_item(make_req(OP_CREATE, 0, 0, 1'b0));
      send_item(make_req(OP_CREATE, 0, 0, 1'b0));
      send_item(make_req(OP_QUERY, 1, 1, 1'b0));
      send_item(make_req(OP_SET_EN, 1, 1, 1'b0));
      send_item(make_req(OP_QUERY, 1, 1, 1'b1));
      send_item(make_req(OP_SET_EN, 1, 1, 1'b1));
      send_item(make_req(OP_QUERY, 1, 2, 1'b0));       // wrong generation
      send_item(make_req(OP_QUERY, 3, 1, 1'b0));       // beyond used slots
      send_item(make_req(OP_DESTROY, 2, 1, 1'b0));
      send_item(make_req(OP_QUERY, 2, 1, 1'b0));       // stale handle
      send_item(make_req(OP_DESTROY, 2, 1, 1'b0));     // double destroy
      send_item(make_req(OP_CREATE, 0, 0, 1'b0));      // reuses slot 2, generation 2
      send_item(make_req(OP_QUERY, 2, 2, 1'b0));
      send_item(make_req(OP_SET_EN, 2, 1, 1'b0));      // stale set does nothing
      send_item(make_req(OP_QUERY, 2, 2, 1'b0));
      send_item(make_req(OP_QUERY, MAX_SLOTS - 1, 65535, 1'b1));
      send_item(make_req(OP_SPARE5, MAX_SLOTS - 1, 65535, 1'b1));
      send_item(make_req(OP_SPARE6, 0, 0, 1'b0));
      send_item(make_req(OP_SPARE7, 1, 1, 1'b1));
      send_item(make_req(OP_DESTROY, 0, 0, 1'b0));     // null handle
      send_item(make_req(OP_CLEAR, 0, 0, 1'b0));
      send_item(make_req(OP_QUERY, 1, 1, 1'b0));       // unreachable after clear
      send_item(make_req(OP_CREATE, 0, 0, 1'b0));
      send_item(make_req(OP_QUERY, 1, 1, 1'b0));
      drain();

      // random traffic under each idling mix
      run_random(110, 0, 0);
      run_random(110, 50, 0);
      run_random(110, 0, 50);
      run_random(110, 13, 13);

      // receiver holds off while requests keep coming
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 1'b1;
      run_random(40, 0, 0);
      drain();

      // clear, create a batch, then free and reuse some of those slots
      send_item(make_req(OP_CLEAR, 0, 0, 1'b0));
      repeat (12) send_item(make_req(OP_CREATE, 0, 0, 1'b0));
      drain();
      stall_pct = 13;
      repeat (8) send_item(retire_item());
      repeat (10) send_item(make_req(OP_CREATE, 0, 0, 1'b0));
      repeat (4) send_item(make_random_item());
      drain();

      run_random(10, 13, 13);
      drain();
      repeat (8) @(posedge clock);

      if (expected_rsp_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_rsp_q.size());
         mismatch_count += expected_rsp_q.size();
      end
      $display("summary: %0d requests, %0d results checked, %0d mismatches",
               items_accepted, results_seen, mismatch_count);
      $display("summary: %0d handles created, %0d creates refused on a full table",
               creates_ok, creates_failed);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gha_pkg.sv
rtl/gha_ram.sv
rtl/generational_handle_allocator.sv
bench/tb_top.sv
